### hw/rtl/igsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igsr_pkg
// Shared constants, types and helpers for ideal-gas state recovery.
// ----------------------------------------------------------------------------
package igsr_pkg;

  localparam int GAMMA_W   = 34;
  localparam int GASR_W    = 46;
  localparam int CFG_IDX_W = 2;

  localparam logic [GAMMA_W-1:0] GAMMA_RST = 34'd6012954214;
  localparam logic [GASR_W-1:0]  GASR_RST  = 46'd1232655679488;
  localparam logic [GAMMA_W-1:0] GAMMA_ONE = 34'h1_0000_0000;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GASR  = 2'd1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_NEG_E = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

  // pipelined long division and root lengths
  localparam int KE_STEPS   = 128;
  localparam int T_STEPS    = 159;
  localparam int SQRT_STEPS = 63;
  localparam int RAD_W      = 2 * SQRT_STEPS;

  typedef struct packed {
    logic        bad;
    logic [63:0] en;
    logic [62:0] rho;
  } d1_side_t;

  typedef struct packed {
    logic        bad;
    logic        eneg;
    logic        pneg;
    logic        psat;
    logic        ovf;
    logic        rzero;
    logic        pz;
    logic [63:0] pout;
  } d2_side_t;

  typedef struct packed {
    logic        bad;
    logic        eneg;
    logic        skip;
    logic        xbig;
    logic        psat;
    logic        tsat;
    logic [63:0] pout;
    logic [63:0] tout;
  } sq_side_t;

  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    mul32 = {32'b0, a} * {32'b0, b};
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    abs64 = v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage

### hw/rtl/igsr_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igsr_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module igsr_sqrt import igsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [RAD_W-1:0]      in_rad,
  input  sq_side_t              in_side,
  output logic                  out_valid,
  output logic [SQRT_STEPS-1:0] out_root,
  output sq_side_t              out_side
);

  logic                  v    [0:SQRT_STEPS];
  logic [64:0]           rem  [0:SQRT_STEPS];
  logic [SQRT_STEPS-1:0] root [0:SQRT_STEPS];
  logic [RAD_W-1:0]      rad  [0:SQRT_STEPS];
  sq_side_t              sd   [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      root[0] <= '0;
      rad[0]  <= in_rad;
      sd[0]   <= in_side;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    logic [66:0] t;
    logic [66:0] trial;
    logic [66:0] diff;
    logic        ge;

    assign t     = {rem[i], rad[i][RAD_W-1 -: 2]};
    assign trial = {2'b00, root[i], 2'b01};
    assign diff  = t - trial;
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? diff[64:0] : t[64:0];
        root[i+1] <= {root[i][SQRT_STEPS-2:0], ge};
        rad[i+1]  <= {rad[i][RAD_W-3:0], 2'b00};
        sd[i+1]   <= sd[i];
      end
    end
  end

  assign out_valid = v[SQRT_STEPS];
  assign out_root  = root[SQRT_STEPS];
  assign out_side  = sd[SQRT_STEPS];

endmodule

### hw/rtl/ideal_gas_state_recovery_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ideal_gas_state_recovery_top
// Pressure, temperature and sound speed from a cell's conserved state.
// ----------------------------------------------------------------------------
// Takes one cell per clock while the output buffer has room and returns one
// result beat per cell, in order. Most of the pipeline depth lies in the two
// long-division pipelines (128 stages for the kinetic energy, 159 for
// temperature) and the square root. A two-entry output buffer decouples
// the sides: the pipeline stalls as a whole only when both entries hold
// results not yet taken. No clearing pass follows reset. Write the gamma
// and gas-constant registers only while the block is idle.
module ideal_gas_state_recovery_top import igsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GASR_W-1:0]    cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // density, momentum_x, momentum_y, momentum_z, energy_density (64 b each)
  input  logic [319:0]         s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pressure (64), temperature (64), sound_speed (63), status (2), zero pad
  output logic [199:0]         m_axis_tdata
);

  // configuration and values derived from it
  logic [GAMMA_W-1:0] gamma;
  logic [GASR_W-1:0]  gasr;
  logic               gm1_neg;
  logic [GAMMA_W-1:0] gm1_mag;
  logic               rzero;
  logic [56:0]        gr_lo, gr_hi;
  logic [79:0]        gr;
  logic               gr_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RST;
      gasr  <= GASR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAMMA: gamma <= cfg_data[GAMMA_W-1:0];
        REG_GASR:  gasr  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    gm1_neg <= gamma < GAMMA_ONE;
    gm1_mag <= (gamma >= GAMMA_ONE) ? (gamma - GAMMA_ONE) : (GAMMA_ONE - gamma);
    rzero   <= gasr == '0;
    // gamma*R from two half-width products
    gr_lo   <= {23'b0, gamma} * {34'b0, gasr[22:0]};
    gr_hi   <= {23'b0, gamma} * {34'b0, gasr[45:23]};
    gr      <= {23'b0, gr_lo} + {gr_hi, 23'b0};
    gr_nz   <= (gamma != '0) && (gasr != '0);
  end

  // global advance: the output buffer has room
  logic       en;
  logic [1:0] count;
  assign en            = count != 2'd2;
  assign s_axis_tready = en;

  // stage 1: magnitudes
  logic [63:0] in_rho, in_en;
  logic [63:0] s1_pm [0:2];
  logic        s1_v, s1_bad;
  logic [62:0] s1_rho;
  logic [63:0] s1_en;

  assign in_rho = s_axis_tdata[63:0];
  assign in_en  = s_axis_tdata[319:256];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bad <= in_rho[63] || (in_rho == '0);
      s1_rho <= in_rho[62:0];
      s1_en  <= in_en;
      for (int k = 0; k < 3; k++) begin
        s1_pm[k] <= abs64(s_axis_tdata[64*(k+1) +: 64]);
      end
    end
  end

  // stage 2: square partial products
  logic        s2_v;
  d1_side_t    s2_sd;
  logic [63:0] s2_ll [0:2];
  logic [63:0] s2_hh [0:2];
  logic [63:0] s2_lh [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sd <= '{bad: s1_bad, en: s1_en, rho: s1_rho};
      for (int k = 0; k < 3; k++) begin
        s2_ll[k] <= mul32(s1_pm[k][31:0], s1_pm[k][31:0]);
        s2_hh[k] <= mul32(s1_pm[k][63:32], s1_pm[k][63:32]);
        s2_lh[k] <= mul32(s1_pm[k][31:0], s1_pm[k][63:32]);
      end
    end
  end

  // stage 3: squares
  logic         s3_v;
  d1_side_t     s3_sd;
  logic [127:0] s3_sq [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sd <= s2_sd;
      for (int k = 0; k < 3; k++) begin
        s3_sq[k] <= {s2_hh[k], s2_ll[k]} + {31'b0, s2_lh[k], 33'b0};
      end
    end
  end

  // kinetic energy divider: sum of squares over twice the density
  logic         d1_v  [0:KE_STEPS];
  logic [63:0]  d1_rem[0:KE_STEPS];
  logic [127:0] d1_nq [0:KE_STEPS];
  d1_side_t     d1_sd [0:KE_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v[0] <= 1'b0;
    end else if (en) begin
      d1_v[0] <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_rem[0] <= '0;
      d1_nq[0]  <= s3_sq[0] + s3_sq[1] + s3_sq[2];
      d1_sd[0]  <= s3_sd;
    end
  end

  for (genvar i = 0; i < KE_STEPS; i++) begin : g_ke
    logic [64:0] t;
    logic [64:0] dv;
    logic [64:0] diff;
    logic        ge;

    assign dv   = {1'b0, d1_sd[i].rho, 1'b0};
    assign t    = {d1_rem[i], d1_nq[i][127]};
    assign diff = t - dv;
    assign ge   = t >= dv;

    always_ff @(posedge clk) begin
      if (rst) begin
        d1_v[i+1] <= 1'b0;
      end else if (en) begin
        d1_v[i+1] <= d1_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d1_rem[i+1] <= ge ? diff[63:0] : t[63:0];
        d1_nq[i+1]  <= {d1_nq[i][126:0], ge};
        d1_sd[i+1]  <= d1_sd[i];
      end
    end
  end

  // stage 5: internal energy, signed
  logic         s5_v, s5_bad;
  logic [62:0]  s5_rho;
  logic [128:0] s5_ed;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= d1_v[KE_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_bad <= d1_sd[KE_STEPS].bad;
      s5_rho <= d1_sd[KE_STEPS].rho;
      s5_ed  <= {{65{d1_sd[KE_STEPS].en[63]}}, d1_sd[KE_STEPS].en}
                - {1'b0, d1_nq[KE_STEPS]};
    end
  end

  // stage 6: sign and magnitude of internal energy
  logic         s6_v, s6_bad, s6_eneg;
  logic [62:0]  s6_rho;
  logic [128:0] s5_neg;
  logic [127:0] s6_emag;

  assign s5_neg = ~s5_ed + 129'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_bad  <= s5_bad;
      s6_rho  <= s5_rho;
      s6_eneg <= s5_ed[128];
      s6_emag <= s5_ed[128] ? s5_neg[127:0] : s5_ed[127:0];
    end
  end

  // stage 7: pressure and divisor partial products
  logic        s7_v, s7_bad, s7_eneg;
  logic [65:0] s7_pe [0:3];
  logic [54:0] s7_rr00, s7_rr01;
  logic [53:0] s7_rr10, s7_rr11;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_bad  <= s6_bad;
      s7_eneg <= s6_eneg;
      for (int j = 0; j < 4; j++) begin
        s7_pe[j] <= {34'b0, s6_emag[32*j +: 32]} * {32'b0, gm1_mag};
      end
      s7_rr00 <= {23'b0, s6_rho[31:0]} * {32'b0, gasr[22:0]};
      s7_rr01 <= {23'b0, s6_rho[31:0]} * {32'b0, gasr[45:23]};
      s7_rr10 <= {23'b0, s6_rho[62:32]} * {31'b0, gasr[22:0]};
      s7_rr11 <= {23'b0, s6_rho[62:32]} * {31'b0, gasr[45:23]};
    end
  end

  // stage 8: partial sums
  logic         s8_v, s8_bad, s8_eneg;
  logic [97:0]  s8_q01, s8_q23;
  logic [108:0] s8_dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_bad  <= s7_bad;
      s8_eneg <= s7_eneg;
      s8_q01  <= {32'b0, s7_pe[0]} + {s7_pe[1], 32'b0};
      s8_q23  <= {32'b0, s7_pe[2]} + {s7_pe[3], 32'b0};
      s8_dv   <= {54'b0, s7_rr00} + {31'b0, s7_rr01, 23'b0}
                 + {23'b0, s7_rr10, 32'b0} + {s7_rr11, 55'b0};
    end
  end

  // stage 9: pressure magnitude
  logic         s9_v, s9_bad, s9_eneg;
  logic [108:0] s9_dv;
  logic [161:0] s8_prod;
  logic [129:0] s9_pmag;

  assign s8_prod = {64'b0, s8_q01} + {s8_q23, 64'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_v <= 1'b0;
    end else if (en) begin
      s9_v <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_bad  <= s8_bad;
      s9_eneg <= s8_eneg;
      s9_dv   <= s8_dv;
      s9_pmag <= s8_prod[161:32];
    end
  end

  // stage 10: pressure output, temperature divider setup
  logic         s9_pneg, s9_psat, s9_ovf;
  logic [63:0]  s9_pout;
  logic [108:0] s9_top;

  assign s9_pneg = (s9_eneg ^ gm1_neg) && (s9_pmag != '0);
  assign s9_psat = s9_pneg ? (s9_pmag > {66'b0, SAT_NEG}) : (s9_pmag > {66'b0, SAT_POS});
  assign s9_pout = s9_psat ? (s9_pneg ? SAT_NEG : SAT_POS)
                           : (s9_pneg ? (~s9_pmag[63:0] + 64'd1) : s9_pmag[63:0]);
  assign s9_top  = {74'b0, s9_pmag[129:95]};
  assign s9_ovf  = rzero || (s9_top >= s9_dv);

  logic         d2_v  [0:T_STEPS];
  logic [108:0] d2_rem[0:T_STEPS];
  logic [158:0] d2_nq [0:T_STEPS];
  logic [108:0] d2_dv [0:T_STEPS];
  d2_side_t     d2_sd [0:T_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_v[0] <= 1'b0;
    end else if (en) begin
      d2_v[0] <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_rem[0] <= s9_ovf ? '0 : s9_top;
      d2_nq[0]  <= {s9_pmag[94:0], 64'b0};
      d2_dv[0]  <= s9_dv;
      d2_sd[0]  <= '{bad: s9_bad, eneg: s9_eneg, pneg: s9_pneg, psat: s9_psat,
                     ovf: s9_ovf, rzero: rzero, pz: (s9_pmag == '0), pout: s9_pout};
    end
  end

  for (genvar i = 0; i < T_STEPS; i++) begin : g_temp
    logic [109:0] t;
    logic [109:0] diff;
    logic         ge;

    assign t    = {d2_rem[i], d2_nq[i][158]};
    assign diff = t - {1'b0, d2_dv[i]};
    assign ge   = t >= {1'b0, d2_dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        d2_v[i+1] <= 1'b0;
      end else if (en) begin
        d2_v[i+1] <= d2_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d2_rem[i+1] <= ge ? diff[108:0] : t[108:0];
        d2_nq[i+1]  <= {d2_nq[i][157:0], ge};
        d2_dv[i+1]  <= d2_dv[i];
        d2_sd[i+1]  <= d2_sd[i];
      end
    end
  end

  // stage 11: temperature output and clamp for the root path
  d2_side_t     tq_sd;
  logic [158:0] tq;
  logic [157:0] tq_mag;
  logic         tq_big, tq_zero, tq_neg, tq_sat;
  logic [63:0]  tq_out;

  assign tq_sd   = d2_sd[T_STEPS];
  assign tq      = d2_nq[T_STEPS];
  assign tq_big  = tq_sd.rzero ? !tq_sd.pz : (tq_sd.ovf || tq[158]);
  assign tq_mag  = (tq_sd.rzero || tq_sd.ovf) ? '0 : tq[157:0];
  assign tq_zero = !tq_big && (tq_mag == '0);
  assign tq_neg  = tq_sd.pneg && !tq_zero;
  assign tq_sat  = tq_big || (tq_neg ? (tq_mag > {94'b0, SAT_NEG})
                                     : (tq_mag > {94'b0, SAT_POS}));
  assign tq_out  = tq_sat ? (tq_neg ? SAT_NEG : SAT_POS)
                          : (tq_neg ? (~tq_mag[63:0] + 64'd1) : tq_mag[63:0]);

  logic         s11_v, s11_tbig;
  sq_side_t     s11_sd;
  logic [157:0] s11_tf;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_v <= 1'b0;
    end else if (en) begin
      s11_v <= d2_v[T_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_tbig <= tq_big;
      s11_tf   <= tq_big ? '0 : tq_mag;
      s11_sd   <= '{bad: tq_sd.bad, eneg: tq_sd.eneg, skip: (tq_sd.eneg || tq_neg),
                    xbig: 1'b0, psat: tq_sd.psat, tsat: tq_sat,
                    pout: tq_sd.pout, tout: tq_out};
    end
  end

  // stages 12..15: gamma*R*T as 32-bit partial products and a sum tree
  logic [31:0] gch [0:2];
  logic [31:0] tch [0:4];

  assign gch[0] = gr[31:0];
  assign gch[1] = gr[63:32];
  assign gch[2] = {16'b0, gr[79:64]};
  for (genvar i = 0; i < 4; i++) begin : g_tch
    assign tch[i] = s11_tf[32*i +: 32];
  end
  assign tch[4] = {2'b0, s11_tf[157:128]};

  logic        s12_v, s12_tbig;
  sq_side_t    s12_sd;
  logic [63:0] s12_p [0:2][0:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_v <= 1'b0;
    end else if (en) begin
      s12_v <= s11_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s12_tbig <= s11_tbig;
      s12_sd   <= s11_sd;
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 5; i++) begin
          s12_p[j][i] <= mul32(gch[j], tch[i]);
        end
      end
    end
  end

  logic         s13_v, s13_tbig;
  sq_side_t     s13_sd;
  logic [191:0] s13_row [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s13_v <= 1'b0;
    end else if (en) begin
      s13_v <= s12_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s13_tbig <= s12_tbig;
      s13_sd   <= s12_sd;
      for (int j = 0; j < 3; j++) begin
        // even chunks do not overlap, nor do odd ones
        s13_row[j] <= {s12_p[j][4], s12_p[j][2], s12_p[j][0]}
                      + {32'b0, s12_p[j][3], s12_p[j][1], 32'b0};
      end
    end
  end

  logic         s14_v, s14_tbig;
  sq_side_t     s14_sd;
  logic [223:0] s14_r01;
  logic [191:0] s14_row2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s14_v <= 1'b0;
    end else if (en) begin
      s14_v <= s13_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s14_tbig <= s13_tbig;
      s14_sd   <= s13_sd;
      s14_r01  <= {32'b0, s13_row[0]} + {s13_row[1], 32'b0};
      s14_row2 <= s13_row[2];
    end
  end

  logic         s15_v, s15_tbig;
  sq_side_t     s15_sd;
  logic [255:0] s15_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s15_v <= 1'b0;
    end else if (en) begin
      s15_v <= s14_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s15_tbig <= s14_tbig;
      s15_sd   <= s14_sd;
      s15_x    <= {32'b0, s14_r01} + {s14_row2, 64'b0};
    end
  end

  // radicand above the root range saturates the sound speed
  sq_side_t sq_in_sd;
  always_comb begin
    sq_in_sd      = s15_sd;
    sq_in_sd.xbig = (s15_tbig && gr_nz) || (s15_x[255:158] != '0);
  end

  logic                  sq_v;
  logic [SQRT_STEPS-1:0] sq_root;
  sq_side_t              sq_sd;

  igsr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s15_v),
    .in_rad   (s15_x[157:32]),
    .in_side  (sq_in_sd),
    .out_valid(sq_v),
    .out_root (sq_root),
    .out_side (sq_sd)
  );

  // result assembly
  logic [62:0]  res_c;
  logic         res_csat;
  logic [1:0]   res_st;
  logic [192:0] res;

  assign res_c    = sq_sd.skip ? '0 : (sq_sd.xbig ? SAT_POS[62:0] : sq_root);
  assign res_csat = !sq_sd.skip && sq_sd.xbig;

  always_comb begin
    if (sq_sd.bad) begin
      res_st = ST_BAD;
    end else if (sq_sd.eneg) begin
      res_st = ST_NEG_E;
    end else if (sq_sd.psat || sq_sd.tsat || res_csat) begin
      res_st = ST_SAT;
    end else begin
      res_st = ST_OK;
    end
  end

  assign res = sq_sd.bad ? {res_st, 191'b0} : {res_st, res_c, sq_sd.tout, sq_sd.pout};

  // two-entry output buffer
  logic [192:0] obuf [0:1];
  logic         wr_ptr, rd_ptr;
  logic         push, pop;

  assign push = en && sq_v;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= res;
    end
  end

  assign m_axis_tvalid = count != 2'd0;
  assign m_axis_tdata  = {7'b0, obuf[rd_ptr]};

endmodule

### hw/rtl/igsr_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igsr_check
// Port-level checks on the result stream of the state recovery block.
// ----------------------------------------------------------------------------
module igsr_check import igsr_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [199:0] m_axis_tdata
);

  logic [63:0] pr, tp;
  logic [62:0] cs;
  logic [1:0]  st;

  assign pr = m_axis_tdata[63:0];
  assign tp = m_axis_tdata[127:64];
  assign cs = m_axis_tdata[190:128];
  assign st = m_axis_tdata[192:191];

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_bad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && st == ST_BAD |-> pr == '0 && tp == '0 && cs == '0)
    else $error("bad density with nonzero results");

  a_neg: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && st == ST_NEG_E |-> cs == '0)
    else $error("negative internal energy with nonzero sound speed");

endmodule

bind ideal_gas_state_recovery_top igsr_check u_igsr_check (.*);

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level checks for ideal-gas state recovery.
// ----------------------------------------------------------------------------
// Drives cells into the block and predicts pressure, temperature, sound
// speed and status with exact wide-integer arithmetic. Every output beat is
// compared against the oldest prediction. The run covers several gamma and
// gas-constant settings, including the extremes, gamma at or below one and a
// zero gas constant. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import igsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [63:0] HALF_RANGE = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  status;
    logic [62:0] sound_speed;
    logic [63:0] temperature;
    logic [63:0] pressure;
  } gas_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GASR_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [319:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;

  logic [GAMMA_W-1:0] gamma_reg;
  logic [GASR_W-1:0]  gasr_reg;
  gas_state_t state_q[$];
  int fail_count = 0;
  int cells_sent = 0;
  int beats_seen = 0;
  int status_hits[4] = '{0, 0, 0, 0};
  bit sink_quiet = 1'b0;
  bit src_quiet = 1'b0;
  int sink_stall = 0;
  int idle_cycles = 0;

  ideal_gas_state_recovery_top uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [511:0] isqrt(input logic [511:0] a);
    logic [511:0] root;
    logic [511:0] cand;
    root = '0;
    for (int i = 255; i >= 0; i--) begin
      cand = root | (512'd1 << i);
      if (cand * cand <= a) root = cand;
    end
    return root;
  endfunction

  // saturate a sign/magnitude value to a signed 64-bit word
  function automatic logic [63:0] clamp_word(input logic neg, input logic [511:0] mag,
                                             inout logic sat);
    if (neg && mag != 0) begin
      if (mag > {448'd0, HALF_RANGE}) begin
        sat = 1'b1;
        return SAT_NEG;
      end
      return -mag[63:0];
    end
    if (mag > {448'd0, SAT_POS}) begin
      sat = 1'b1;
      return SAT_POS;
    end
    return mag[63:0];
  endfunction

  function automatic gas_state_t recover_state(input logic [63:0] rho, input logic [63:0] px,
                                               input logic [63:0] py, input logic [63:0] pz,
                                               input logic [63:0] en);
    gas_state_t r;
    logic [511:0] sq, ke, e_mag, gm1_mag, p_mag, t_mag, rad, root;
    logic e_neg, gm1_neg, p_neg, t_neg, sat;
    r = '0;
    sat = 1'b0;
    if ($signed(rho) <= 0) begin
      r.status = ST_BAD;
      return r;
    end
    sq = {448'd0, abs64(px)} * {448'd0, abs64(px)} + {448'd0, abs64(py)} * {448'd0, abs64(py)}
       + {448'd0, abs64(pz)} * {448'd0, abs64(pz)};
    ke = sq / ({448'd0, rho} << 1);
    if (en[63]) begin
      e_mag = {448'd0, abs64(en)} + ke;
      e_neg = 1'b1;
    end else if ({448'd0, en} >= ke) begin
      e_mag = {448'd0, en} - ke;
      e_neg = 1'b0;
    end else begin
      e_mag = ke - {448'd0, en};
      e_neg = 1'b1;
    end
    if (e_mag == 0) e_neg = 1'b0;
    gm1_neg = gamma_reg < GAMMA_ONE;
    gm1_mag = gm1_neg ? {478'd0, GAMMA_ONE - gamma_reg} : {478'd0, gamma_reg - GAMMA_ONE};
    p_mag = (e_mag * gm1_mag) >> 32;
    p_neg = (e_neg != gm1_neg) && p_mag != 0;
    r.pressure = clamp_word(p_neg, p_mag, sat);
    if (gasr_reg == 0) begin
      // zero gas constant: temperature runs off toward the pressure's sign
      t_mag = (p_mag == 0) ? '0 : (512'd1 << 64);
      t_neg = (p_mag == 0) ? 1'b0 : p_neg;
      if (p_mag != 0) sat = 1'b1;
    end else begin
      t_mag = (p_mag << 64) / ({448'd0, rho} * {466'd0, gasr_reg});
      t_neg = p_neg && t_mag != 0;
    end
    r.temperature = clamp_word(t_neg, t_mag, sat);
    if (!(e_neg || t_neg)) begin
      rad = ({478'd0, gamma_reg} * {466'd0, gasr_reg} * t_mag) >> 32;
      root = isqrt(rad);
      if (root > {448'd0, SAT_POS}) begin
        sat = 1'b1;
        r.sound_speed = SAT_POS[62:0];
      end else begin
        r.sound_speed = root[62:0];
      end
    end
    r.status = e_neg ? ST_NEG_E : (sat ? ST_SAT : ST_OK);
    return r;
  endfunction

  // output side: random stall bursts, none once the sink goes quiet
  always @(posedge clk) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (!sink_quiet && !rst && $urandom_range(0, 9) == 0) begin
      sink_stall <= $urandom_range(0, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    gas_state_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = gas_state_t'(m_axis_tdata[192:0]);
      beats_seen++;
      if (state_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, m_axis_tdata);
        fail_count++;
      end else begin
        want = state_q.pop_front();
        status_hits[want.status]++;
        if (got.pressure !== want.pressure) begin
          $display("%0t: pressure expected %h actual %h", $realtime, want.pressure,
                   got.pressure);
          fail_count++;
        end
        if (got.temperature !== want.temperature) begin
          $display("%0t: temperature expected %h actual %h", $realtime, want.temperature,
                   got.temperature);
          fail_count++;
        end
        if (got.sound_speed !== want.sound_speed) begin
          $display("%0t: sound_speed expected %h actual %h", $realtime, want.sound_speed,
                   got.sound_speed);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                   got.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (!s_axis_tvalid && state_q.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress, %0d results outstanding", $realtime, state_q.size());
        $display("tb failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // send one cell; valid stays high after the beat so back-to-back cells flow
  task automatic send_cell(input logic [63:0] rho, input logic [63:0] px,
                           input logic [63:0] py, input logic [63:0] pz,
                           input logic [63:0] en);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {en, pz, py, px, rho};
    do @(posedge clk); while (!s_axis_tready);
    state_q.push_back(recover_state(rho, px, py, pz, en));
    cells_sent++;
    if (!src_quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (state_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GASR_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAMMA: gamma_reg = val[GAMMA_W-1:0];
      REG_GASR:  gasr_reg = val;
      default: begin end
    endcase
    @(posedge clk);
  endtask

  task automatic send_corner_cells();
    logic [63:0] one;
    one = 64'h1_0000_0000;
    send_cell(64'd0, one, one, one, one);
    send_cell(-one, one, 64'd0, 64'd0, one);
    send_cell(SAT_NEG, 64'd0, 64'd0, 64'd0, 64'd0);
    send_cell(one, 64'd0, 64'd0, 64'd0, 64'd0);
    send_cell(one, 2 * one, 64'd0, 64'd0, 2 * one);
    send_cell(one, 3 * one, 4 * one, 12 * one, 100 * one);
    send_cell(64'd1, SAT_NEG, SAT_NEG, SAT_NEG, SAT_POS);
    send_cell(SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS);
    send_cell(SAT_POS, 64'd0, 64'd0, 64'd0, SAT_NEG);
    send_cell(64'd1, 64'd0, 64'd0, 64'd0, SAT_POS);
    send_cell(64'd1, 64'd0, 64'd0, 64'd0, -64'd1);
    send_cell(one, one, 64'd0, 64'd0, -64'd1);
    send_cell(64'd1, 64'd1, 64'd0, 64'd0, 64'd0);
    send_cell(one >> 8, 64'd0, 64'd0, 64'd0, 1000 * one);
    send_cell(1000 * one, 64'd0, -(50 * one), 64'd0, 2500000 * one);
    send_cell(64'hFFFF_FFFF_FFFF_FFFF, one, one, one, one);
    send_cell(64'd1, 64'd0, 64'd0, SAT_POS, SAT_POS);
  endtask

  function automatic logic [63:0] signed_mag(input int unsigned int_max);
    logic [63:0] m;
    m = {32'(int'($urandom_range(0, int_max))), $urandom};
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic send_random_cell();
    logic [63:0] v[5];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        // physically plausible cell with random content
        v[0] = {32'($urandom_range(0, 2000)), $urandom};
        v[1] = signed_mag(3000);
        v[2] = signed_mag(3000);
        v[3] = $urandom_range(0, 3) == 0 ? 64'd0 : signed_mag(3000);
        v[4] = {32'($urandom_range(0, 32'h3FFF_FFFF)), $urandom};
      end
      6, 7: foreach (v[i]) v[i] = rand_word();
      8: begin
        v[0] = {32'd0, $urandom} >> $urandom_range(0, 31);
        foreach (v[i]) if (i > 0) v[i] = rand_word() >>> $urandom_range(0, 63);
      end
      default: foreach (v[i]) begin
        case ($urandom_range(0, 4))
          0: v[i] = SAT_POS;
          1: v[i] = SAT_NEG;
          2: v[i] = 64'd1;
          3: v[i] = '1;
          default: v[i] = '0;
        endcase
      end
    endcase
    send_cell(v[0], v[1], v[2], v[3], v[4]);
  endtask

  task automatic test_reset_settings();
    send_corner_cells();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_GAMMA, 46'd12884901888);
    write_reg(REG_GASR, 46'd42949672960000);
    send_corner_cells();
    write_reg(REG_GAMMA, 46'd4294967297);
    write_reg(REG_GASR, 46'd1);
    send_corner_cells();
  endtask

  task automatic test_odd_registers();
    // gamma below one, zero gas constant, spare indexes, bits above gamma width
    write_reg(REG_GAMMA, 46'h0_8000_0000);
    write_reg(REG_GASR, 46'd0);
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, 46'h1234_5678_9ABC);
    send_corner_cells();
    write_reg(REG_GAMMA, {12'hFFF, 34'h1_0000_0000});
    write_reg(REG_GASR, '1);
    send_corner_cells();
    write_reg(REG_GAMMA, 46'd0);
    send_corner_cells();
  endtask

  task automatic test_random_cells();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        write_reg(REG_GAMMA, 46'(GAMMA_RST));
        write_reg(REG_GASR, GASR_RST);
      end else begin
        write_reg(REG_GAMMA, 46'($urandom_range(0, 1) ? {$urandom_range(1, 2), $urandom}
                                                      : {2'd0, $urandom}));
        write_reg(REG_GASR, $urandom_range(0, 3) == 0 ? {14'($urandom), $urandom}
                                                      : 46'({$urandom_range(0, 10000), 32'd0}));
      end
      if (phase == 6) begin
        src_quiet = 1'b1;
        sink_quiet = 1'b1;
      end
      for (int n = 0; n < 160; n++) begin
        send_random_cell();
        // hold the source until the pipeline has emptied once
        if (phase == 2 && n == 80) drain();
      end
    end
  endtask

  initial begin
    gamma_reg = GAMMA_RST;
    gasr_reg = GASR_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_register_extremes();
    test_odd_registers();
    test_random_cells();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("cells %0d, results %0d under several gamma and gas-constant settings",
             cells_sent, beats_seen);
    $display("status ok %0d, bad density %0d, negative energy %0d, saturated %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (fail_count == 0 && state_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/igsr_pkg.sv
hw/rtl/igsr_sqrt.sv
hw/rtl/ideal_gas_state_recovery_top.sv
hw/rtl/igsr_check.sv
dv/tb.sv
